[rtl/ms_pkg.sv]
package ms_pkg;

    // Width of the value ports.
    localparam int OUT_W = 32;

    // Command codes on i_action.
    typedef enum logic [2:0] {
        ACT_PUSH    = 3'd0,
        ACT_POP     = 3'd1,
        ACT_TOP     = 3'd2,
        ACT_PEEKMAX = 3'd3,
        ACT_POPMAX  = 3'd4
    } t_action;

    // Status codes on o_status.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP,
        CELL_FCLR,
        CELL_MARK,
        CELL_CLOSE,
        CELL_RELAX
    } t_cell_op;

endpackage

[rtl/max_stack.sv]
// Bounded stack of signed words with max tracking. A command beat is taken at
// a rising edge where start is high and busy is low; exactly one result beat
// follows, registered at that edge, driven for a single cycle and flagged by o_valid.
// The receiver cannot stall, so sample o_result_value and o_status whenever
// o_valid is high. Push, pop, top, peek-max and the unused codes leave busy
// low: one command per clock. Pop-max also returns its result in the next
// cycle, but then keeps busy high while the cell chain repairs itself: a
// mark flag ripples one cell per clock from the top to find the topmost
// copy of the maximum, the entries below it close up, and the running
// maximum ripples back up one cell per clock. Popping or peeking an empty
// stack returns status empty, and a push onto a full stack is dropped with
// status full; result_value is zero in both cases and for a push. Stored
// words are DATA_WIDTH bits; pushed values are sign-extended or truncated
// to that width, and returned words are sign-extended or truncated to 32
// bits.
module max_stack import ms_pkg::*; #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [2:0]              i_action,
    input  logic signed [OUT_W-1:0] i_value,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_result_value,
    output logic [1:0]              o_status
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MARK,
        S_CLOSE,
        S_RELAX
    } t_state;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_occ, n_occ;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_valid, n_valid;
    logic signed [OUT_W-1:0] r_res, n_res;
    t_status                 r_status, n_status;
    t_cell_op                w_op;

    // Cell chain taps: cell 0 is the top of the stack.
    logic signed [DATA_WIDTH-1:0] w_e [DEPTH];
    logic signed [DATA_WIDTH-1:0] w_m [DEPTH];
    logic                         w_f [DEPTH];

    logic signed [DATA_WIDTH-1:0] w_push_v;
    logic signed [DATA_WIDTH-1:0] w_push_m;
    logic                         w_empty;
    logic                         w_full;

    assign w_empty  = (r_occ == '0);
    assign w_full   = (r_occ == CNT_W'(DEPTH));
    assign w_push_v = DATA_WIDTH'(i_value);
    // Running max of the new top: the pushed word, or the old top's max.
    assign w_push_m = (w_empty || (w_push_v >= w_m[0])) ? w_push_v : w_m[0];

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_occ    = r_occ;
        n_cnt    = r_cnt;
        n_valid  = 1'b0;
        n_res    = r_res;
        n_status = r_status;
        w_op     = CELL_HOLD;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_valid  = 1'b1;
                    n_res    = '0;
                    n_status = ST_OK;
                    case (t_action'(i_action))
                        ACT_PUSH: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_op  = CELL_PUSH;
                                n_occ = r_occ + 1'b1;
                            end
                        end
                        ACT_POP: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_res = OUT_W'(w_e[0]);
                                w_op  = CELL_POP;
                                n_occ = r_occ - 1'b1;
                            end
                        end
                        ACT_TOP: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_res = OUT_W'(w_e[0]);
                            end
                        end
                        ACT_PEEKMAX: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_res = OUT_W'(w_m[0]);
                            end
                        end
                        ACT_POPMAX: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                // Result is known now; the chain repairs itself after.
                                n_res   = OUT_W'(w_m[0]);
                                w_op    = CELL_FCLR;
                                n_cnt   = r_occ - 1'b1;
                                n_state = S_MARK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MARK: begin
                // Advance the mark flag one cell per clock.
                w_op = CELL_MARK;
                if (r_cnt == '0) begin
                    n_state = S_CLOSE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_CLOSE: begin
                // Drop the marked entry; everything below moves up one cell.
                w_op  = CELL_CLOSE;
                n_occ = r_occ - 1'b1;
                if (r_occ == CNT_W'(1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt   = r_occ - CNT_W'(2);
                    n_state = S_RELAX;
                end
            end
            S_RELAX: begin
                // Rebuild the running max from the bottom up.
                w_op = CELL_RELAX;
                if (r_cnt == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res    <= n_res;
        r_status <= n_status;
        r_cnt    <= n_cnt;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_valid <= n_valid;
        end
    end

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_cell
            logic signed [DATA_WIDTH-1:0] w_up_e;
            logic signed [DATA_WIDTH-1:0] w_up_m;
            logic                         w_up_f;
            logic signed [DATA_WIDTH-1:0] w_dn_e;
            logic signed [DATA_WIDTH-1:0] w_dn_m;
            logic                         w_last;

            if (k == 0) begin : g_top
                assign w_up_e = w_push_v;
                assign w_up_m = w_push_m;
                assign w_up_f = 1'b0;
            end else begin : g_mid
                assign w_up_e = w_e[k-1];
                assign w_up_m = w_m[k-1];
                assign w_up_f = w_f[k-1];
            end

            if (k == DEPTH - 1) begin : g_bot
                assign w_dn_e = w_e[k];
                assign w_dn_m = w_m[k];
            end else begin : g_inner
                assign w_dn_e = w_e[k+1];
                assign w_dn_m = w_m[k+1];
            end

            assign w_last = (r_occ == CNT_W'(k + 1));

            ms_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_op    (w_op),
                .i_max   (w_m[0]),
                .i_last  (w_last),
                .i_up_e  (w_up_e),
                .i_up_m  (w_up_m),
                .i_up_f  (w_up_f),
                .i_dn_e  (w_dn_e),
                .i_dn_m  (w_dn_m),
                .o_e     (w_e[k]),
                .o_m     (w_m[k]),
                .o_f     (w_f[k])
            );
        end
    endgenerate

    assign o_valid        = r_valid;
    assign o_result_value = r_res;
    assign o_status       = r_status;

endmodule

[rtl/ms_cell.sv]
module ms_cell import ms_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cell_op                     i_op,
    input  logic signed [DATA_WIDTH-1:0] i_max,
    input  logic                         i_last,
    input  logic signed [DATA_WIDTH-1:0] i_up_e,
    input  logic signed [DATA_WIDTH-1:0] i_up_m,
    input  logic                         i_up_f,
    input  logic signed [DATA_WIDTH-1:0] i_dn_e,
    input  logic signed [DATA_WIDTH-1:0] i_dn_m,
    output logic signed [DATA_WIDTH-1:0] o_e,
    output logic signed [DATA_WIDTH-1:0] o_m,
    output logic                         o_f
);

    logic signed [DATA_WIDTH-1:0] r_e, n_e;
    logic signed [DATA_WIDTH-1:0] r_m, n_m;
    logic                         r_f, n_f;
    logic signed [DATA_WIDTH-1:0] w_relax_m;

    // Max of this entry and everything below it.
    assign w_relax_m = (r_e >= i_dn_m) ? r_e : i_dn_m;

    always_comb begin
        n_e = r_e;
        n_m = r_m;
        n_f = r_f;
        case (i_op)
            CELL_PUSH: begin
                n_e = i_up_e;
                n_m = i_up_m;
            end
            CELL_POP: begin
                n_e = i_dn_e;
                n_m = i_dn_m;
            end
            CELL_FCLR: begin
                n_f = 1'b0;
            end
            CELL_MARK: begin
                // at or below the topmost copy of the maximum
                n_f = i_up_f | (r_e == i_max);
            end
            CELL_CLOSE: begin
                if (r_f) begin
                    n_e = i_dn_e;
                    n_m = i_dn_m;
                end
            end
            CELL_RELAX: begin
                n_m = i_last ? r_e : w_relax_m;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_e <= n_e;
        r_m <= n_m;
        if (!i_rst_n) begin
            r_f <= 1'b0;
        end else begin
            r_f <= n_f;
        end
    end

    assign o_e = r_e;
    assign o_m = r_m;
    assign o_f = r_f;

endmodule

[rtl/ms_checker.sv]
module ms_checker import ms_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input logic [2:0]              i_action,
    input logic                    o_valid,
    input logic signed [OUT_W-1:0] o_result_value,
    input logic [1:0]              o_status
);

    // Every accepted command beat yields a result beat on the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_valid)
        else $error("no result beat after an accepted command");

    // No result beat without a command beat just before it.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy))
        else $error("result beat without a command");

    // A failed command returns zero.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_result_value == '0))
        else $error("nonzero value with error status");

    // A full flag only answers a push.
    a_push_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_action != ACT_PUSH)) |=> (o_status != ST_FULL))
        else $error("full status for a command other than push");

endmodule

bind max_stack ms_checker u_ms_checker (.*);
